/* design/pfx_pkg.sv */
package pfx_pkg;

  localparam int DATA_W          = 32;
  localparam int STACK_DEPTH_DEF = 128;
  localparam int DIV_CNT_W       = $clog2(DATA_W);

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_OTHER
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_DIV,
    S_DIV_FIX,
    S_COMMIT,
    S_DROP,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    push_digit;
    logic    rd_lhs;
    logic    rd_below;
    logic    set_err;
    status_t err_code;
    logic    exec;
    logic    div_step;
    logic    div_fix;
    logic    commit;
    logic    drop_two;
    logic    finish;
  } pfx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_space;
    logic is_digit;
    op_t  op;
    logic last;
    logic err_set;
    logic cnt_lt2;
    logic cnt_eq2;
    logic full;
    logic rhs_zero;
    logic div_last;
    logic out_full;
  } pfx_sts_t;

  function automatic op_t op_decode(input logic [7:0] c);
    op_t op;
    case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  op = OP_OTHER;
    endcase
    return op;
  endfunction

endpackage

/* design/pfx_if.sv */
interface pfx_in_if;
  import pfx_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_expr;

  modport source (output valid, output char_code, output end_of_expr, input ready);
  modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface pfx_out_if;
  import pfx_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [1:0]               status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

/* design/postfix_expression_evaluator_top.sv */
// a digit or space passes IDLE and DECODE; + - * add EXEC and COMMIT; / runs EXEC, 32 divide steps, DIV_FIX, COMMIT
// the end beat adds FINISH, held while the output register is full; its result shows the cycle after
// throughput: one character at a time, set by the controller and the 32-step divider
// a finished result waits in an output register while the next character is taken
// rst_n (synchronous, active low) empties the stack and clears the error; no clearing pass
module postfix_expression_evaluator_top
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  pfx_in_if.sink   in_chan,
  pfx_out_if.source out_chan
);

  pfx_cmd_t cmd;
  pfx_sts_t sts;
  logic     in_ready;

  assign in_chan.ready = in_ready;

  // sequencer
  pfx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stack, alu and divider
  pfx_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char    (in_chan.char_code),
    .in_last    (in_chan.end_of_expr),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_value  (out_chan.result_value),
    .out_status (out_chan.status)
  );

endmodule

/* design/pfx_ctrl.sv */
module pfx_ctrl
  import pfx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pfx_sts_t sts,
  output pfx_cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.err_code = ST_OK;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = sts.last ? S_FINISH : S_IDLE;
        if (sts.err_set || sts.is_space) begin
          // sticky error or blank: nothing to do
        end else if (sts.is_digit) begin
          if (sts.full) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_OVER;
          end else begin
            cmd.push_digit = 1'b1;
          end
        end else if (sts.cnt_lt2) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_UNDER;
        end else if (sts.op == OP_DIV && sts.rhs_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DIVZ;
        end else if (sts.op == OP_OTHER) begin
          cmd.rd_below = !sts.cnt_eq2;
          state_nxt    = S_DROP;
        end else begin
          cmd.rd_lhs = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (sts.op == OP_DIV) ? S_DIV : S_COMMIT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DIV_FIX;
        end
      end
      S_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = sts.last ? S_FINISH : S_IDLE;
      end
      S_DROP: begin
        cmd.drop_two = 1'b1;
        state_nxt    = sts.last ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (!sts.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* design/pfx_dpath.sv */
module pfx_dpath
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [7:0]               in_char,
  input  logic                     in_last,
  input  pfx_cmd_t                 cmd,
  output pfx_sts_t                 sts,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic [1:0]               out_status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  localparam logic [CW-1:0] CNT_ONE   = CW'(1);
  localparam logic [CW-1:0] CNT_TWO   = CW'(2);
  localparam logic [CW-1:0] CNT_THREE = CW'(3);
  localparam logic [CW-1:0] CNT_FULL  = CW'(STACK_DEPTH);

  // entries below the top; the top itself lives in tos_r
  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic [7:0]          char_r;
  logic                last_r;
  logic [CW-1:0]       cnt_r;
  status_t             err_r;
  logic [DATA_W-1:0]   tos_r;
  logic [DATA_W-1:0]   rdata_r;
  logic [DATA_W-1:0]   res_r;
  logic [DATA_W-1:0]   quo_r;
  logic [DATA_W-1:0]   rem_r;
  logic [DATA_W-1:0]   dvs_r;
  logic                neg_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_value_r;
  status_t             out_status_r;

  op_t                 op;
  logic [CW-1:0]       cnt_m1, cnt_m2, cnt_m3;
  logic [AW-1:0]       rd_addr;
  logic [DATA_W:0]     rem_sh, rem_diff;
  logic [DATA_W-1:0]   lhs_mag, rhs_mag;
  logic [DATA_W-1:0]   digit_val;
  status_t             fin_status;

  assign op        = op_decode(char_r);
  assign cnt_m1    = cnt_r - CNT_ONE;
  assign cnt_m2    = cnt_r - CNT_TWO;
  assign cnt_m3    = cnt_r - CNT_THREE;
  assign rd_addr   = cmd.rd_below ? cnt_m3[AW-1:0] : cnt_m2[AW-1:0];
  assign digit_val = DATA_W'(char_r - CH_ZERO);
  assign lhs_mag   = rdata_r[DATA_W-1] ? (DATA_W'(0) - rdata_r) : rdata_r;
  assign rhs_mag   = tos_r[DATA_W-1] ? (DATA_W'(0) - tos_r) : tos_r;

  // one restoring divide step
  assign rem_sh   = {rem_r, quo_r[DATA_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  // status to controller
  always_comb begin
    sts          = '0;
    sts.is_space = (char_r == CH_SPACE);
    sts.is_digit = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
    sts.op       = op;
    sts.last     = last_r;
    sts.err_set  = (err_r != ST_OK);
    sts.cnt_lt2  = (cnt_r < CNT_TWO);
    sts.cnt_eq2  = (cnt_r == CNT_TWO);
    sts.full     = (cnt_r >= CNT_FULL);
    sts.rhs_zero = (tos_r == '0);
    sts.div_last = (dcnt_r == DIV_CNT_W'(DATA_W - 1));
    sts.out_full = out_valid_r;
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      char_r <= in_char;
      last_r <= in_last;
    end
  end

  // stack memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.push_digit && cnt_r != '0) begin
      mem[cnt_m1[AW-1:0]] <= tos_r;
    end
    if (cmd.rd_lhs || cmd.rd_below) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // stack count, top of stack and error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= ST_OK;
    end else begin
      if (cmd.push_digit) begin
        cnt_r <= cnt_r + CNT_ONE;
      end else if (cmd.commit) begin
        cnt_r <= cnt_m1;
      end else if (cmd.drop_two) begin
        cnt_r <= cnt_m2;
      end else if (cmd.finish) begin
        cnt_r <= '0;
      end
      if (cmd.set_err) begin
        err_r <= cmd.err_code;
      end else if (cmd.finish) begin
        err_r <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_digit) begin
      tos_r <= digit_val;
    end else if (cmd.commit) begin
      tos_r <= res_r;
    end else if (cmd.drop_two) begin
      tos_r <= rdata_r;
    end
  end

  // arithmetic unit and iterative divider
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (op)
        OP_ADD:  res_r <= rdata_r + tos_r;
        OP_SUB:  res_r <= rdata_r - tos_r;
        OP_MUL:  res_r <= rdata_r * tos_r;
        default: res_r <= '0;
      endcase
      quo_r  <= lhs_mag;
      dvs_r  <= rhs_mag;
      rem_r  <= '0;
      neg_r  <= rdata_r[DATA_W-1] ^ tos_r[DATA_W-1];
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!rem_diff[DATA_W]) begin
        rem_r <= rem_diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + DIV_CNT_W'(1);
    end else if (cmd.div_fix) begin
      res_r <= neg_r ? (DATA_W'(0) - quo_r) : quo_r;
    end
  end

  // final status on the end beat
  always_comb begin
    if (err_r != ST_OK) begin
      fin_status = err_r;
    end else if (cnt_r == '0) begin
      fin_status = ST_UNDER;
    end else begin
      fin_status = ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value_r  <= (fin_status == ST_OK) ? tos_r : '0;
      out_status_r <= fin_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = signed'(out_value_r);
  assign out_status = out_status_r;

endmodule
